// File: rtl/triangle_face_normal_unit_top_defines.svh
// Assertion macros shared by the triangle face normal unit
`ifndef TRIANGLE_FACE_NORMAL_UNIT_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_TOP_DEFINES_SVH

// Condition now implies consequence in the same cycle
`define TFN_ASSERT_NOW(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("tfn assertion failed");

// Condition now implies consequence in the next cycle
`define TFN_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("tfn assertion failed");

`endif

// File: rtl/tfn_pkg.sv
// Shared types, constants and helpers of the triangle face normal unit
package tfn_pkg;

   localparam int VERTEX_SLOTS_DEF    = 16;
   localparam int COORD_FRAC_BITS_DEF = 14;
   localparam int COORD_W             = 16;
   localparam int SLOT_W              = 4;
   localparam int IDX_W               = 8;
   localparam int STEP_W              = 6;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TRI  = 1'b1;

   // last step of each fixed-length phase
   localparam logic [STEP_W-1:0] READ_LAST   = 6'd3;
   localparam logic [STEP_W-1:0] CROSS_LAST  = 6'd6;
   localparam logic [STEP_W-1:0] SQUARE_LAST = 6'd9;
   localparam logic [STEP_W-1:0] SQRT_LAST   = 6'd36;

   localparam logic [1:0] SEL_LAST = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ   = 7'b0000010,
      ST_CROSS  = 7'b0000100,
      ST_SQUARE = 7'b0001000,
      ST_SQRT   = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              load_we;
      logic              tri_start;
      logic              read_en;
      logic              cross_en;
      logic              square_en;
      logic              sqrt_en;
      logic              div_en;
      logic              emit_fire;
      logic [STEP_W-1:0] step;
      logic [1:0]        sel;
   } dp_cmd_type;

   typedef struct packed {
      logic degenerate;
   } dp_status_type;

   // reduce a slot number modulo the table depth by repeated subtraction
   function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] s,
                                                  input int unsigned n);
      logic [SLOT_W-1:0] r;
      r = s;
      for (int i = 0; i < 6; i++) begin
         if (32'(r) >= n) begin
            r = r - SLOT_W'(n);
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/tfn_req_if.sv
// Request channel interface of the triangle face normal unit
interface tfn_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [3:0]        vertex_slot;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;
   logic [3:0]        corner_a;
   logic [3:0]        corner_b;
   logic [3:0]        corner_c;
   logic              final_triangle;

   modport source (output valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                   corner_a, corner_b, corner_c, final_triangle, input ready);
   modport sink (input valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                 corner_a, corner_b, corner_c, final_triangle, output ready);
endinterface

// File: rtl/tfn_rsp_if.sv
// Result channel interface of the triangle face normal unit
interface tfn_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         vertex_index;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic               degenerate;
   logic               last_of_triangle;

   modport source (output valid, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y,
                   norm_z, degenerate, last_of_triangle, input ready);
   modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y,
                 norm_z, degenerate, last_of_triangle, output ready);
endinterface

// File: rtl/tfn_ram.sv
// Generic single-write, single-read RAM with registered read data
module tfn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/tfn_ctrl.sv
// Controller state machine sequencing the face normal datapath
`include "triangle_face_normal_unit_top_defines.svh"
module tfn_ctrl #(
   parameter int COORD_FRAC_BITS = tfn_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tfn_pkg::dp_status_type status,
   output tfn_pkg::dp_cmd_type    cmd
);
   localparam logic [tfn_pkg::STEP_W-1:0] DIV_LAST = tfn_pkg::STEP_W'(COORD_FRAC_BITS + 2);

   tfn_pkg::state_type              state_ff, state_in;
   logic [tfn_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [1:0]                      sel_ff, sel_in;
   logic                            req_fire;
   logic                            rsp_fire;

   assign req_ready = (state_ff == tfn_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tfn_pkg::ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 1'b1;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.step = step_ff;
      cmd.sel  = sel_ff;
      case (state_ff)
         tfn_pkg::ST_IDLE: begin
            step_in = '0;
            sel_in  = '0;
            if (req_fire) begin
               if (req_mode == tfn_pkg::MODE_LOAD) begin
                  cmd.load_we = 1'b1;
               end else begin
                  cmd.tri_start = 1'b1;
                  state_in      = tfn_pkg::ST_READ;
               end
            end
         end
         tfn_pkg::ST_READ: begin
            cmd.read_en = 1'b1;
            if (step_ff == tfn_pkg::READ_LAST) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_CROSS;
            end
         end
         tfn_pkg::ST_CROSS: begin
            cmd.cross_en = 1'b1;
            if (step_ff == tfn_pkg::CROSS_LAST) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SQUARE;
            end
         end
         tfn_pkg::ST_SQUARE: begin
            cmd.square_en = 1'b1;
            if (step_ff == tfn_pkg::SQUARE_LAST) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SQRT;
            end
         end
         tfn_pkg::ST_SQRT: begin
            cmd.sqrt_en = 1'b1;
            if (step_ff == tfn_pkg::SQRT_LAST) begin
               step_in  = '0;
               sel_in   = '0;
               state_in = status.degenerate ? tfn_pkg::ST_EMIT : tfn_pkg::ST_DIV;
            end
         end
         tfn_pkg::ST_DIV: begin
            cmd.div_en = 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in = '0;
               if (sel_ff == tfn_pkg::SEL_LAST) begin
                  sel_in   = '0;
                  state_in = tfn_pkg::ST_EMIT;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         tfn_pkg::ST_EMIT: begin
            step_in = '0;
            if (rsp_fire) begin
               cmd.emit_fire = 1'b1;
               if (sel_ff == tfn_pkg::SEL_LAST) begin
                  sel_in   = '0;
                  state_in = tfn_pkg::ST_IDLE;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = tfn_pkg::ST_IDLE;
            step_in  = '0;
            sel_in   = '0;
         end
      endcase
   end

   // hold state, step and selector
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfn_pkg::ST_IDLE;
         step_ff  <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
      end
   end

   `TFN_ASSERT_NEXT(a_tri_to_read, req_fire && req_mode == tfn_pkg::MODE_TRI,
                    state_ff == tfn_pkg::ST_READ && step_ff == '0)
   `TFN_ASSERT_NEXT(a_last_rsp_idle, rsp_fire && sel_ff == tfn_pkg::SEL_LAST,
                    state_ff == tfn_pkg::ST_IDLE)
   `TFN_ASSERT_NEXT(a_read_to_cross,
                    state_ff == tfn_pkg::ST_READ && step_ff == tfn_pkg::READ_LAST,
                    state_ff == tfn_pkg::ST_CROSS && step_ff == '0)
   `TFN_ASSERT_NOW(a_busy_not_ready, state_ff != tfn_pkg::ST_IDLE, !req_ready)
endmodule

// File: rtl/tfn_datapath.sv
// Datapath: vertex table, shared multiplier, square root and divider
module tfn_datapath #(
   parameter int VERTEX_SLOTS    = tfn_pkg::VERTEX_SLOTS_DEF,
   parameter int COORD_FRAC_BITS = tfn_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tfn_req_if.sink                req_ch,
   tfn_rsp_if.source              rsp_ch,
   input  tfn_pkg::dp_cmd_type    cmd,
   output tfn_pkg::dp_status_type status
);
   localparam int AW    = $clog2(VERTEX_SLOTS);
   localparam int VW    = 3 * tfn_pkg::COORD_W;
   localparam int SUM_W = 70;
   localparam int ROOT_W = 35;
   localparam int REM_W = 38;
   localparam int DW    = 36 + COORD_FRAC_BITS;
   localparam int QW    = COORD_FRAC_BITS + 1;
   localparam logic [tfn_pkg::STEP_W-1:0] DIV_ITER_LAST =
      tfn_pkg::STEP_W'(COORD_FRAC_BITS + 1);
   localparam logic [tfn_pkg::STEP_W-1:0] DIV_LAST = tfn_pkg::STEP_W'(COORD_FRAC_BITS + 2);
   localparam logic [QW-1:0] ONE = QW'(1) << COORD_FRAC_BITS;

   localparam logic [1:0] PART_HH = 2'd0;
   localparam logic [1:0] PART_HL = 2'd1;
   localparam logic [1:0] PART_LL = 2'd2;

   logic [AW-1:0]              waddr, raddr;
   logic [VW-1:0]              rdata;
   logic [tfn_pkg::SLOT_W-1:0] corner_ff [3];
   logic                       final_ff;
   logic [VW-1:0]              pos_ff [3];
   logic signed [17:0]         e1 [3];
   logic signed [17:0]         e2 [3];
   logic signed [17:0]         mul_a, mul_b;
   logic signed [35:0]         prod_ff;
   logic [1:0]                 part_in, part_ff;
   logic [1:0]                 sq_comp;
   logic signed [34:0]         cr_ff [3];
   logic [33:0]                cr_mag [3];
   logic [2:0]                 cross_idx;
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           sq_term;
   logic [SUM_W-1:0]           sop_ff;
   logic [REM_W-1:0]           rem_ff, rem_sh, trial;
   logic [ROOT_W-1:0]          root_ff;
   logic [DW-1:0]              drem_ff, dsh_ff;
   logic [QW-1:0]              q_ff, q_clamp;
   logic                       sign_ff;
   logic signed [63:0]         q_signed;
   logic [15:0]                norm_ff [3];
   logic [tfn_pkg::IDX_W-1:0]  index_ff;
   logic [VW-1:0]              pos_sel;

   // vertex table
   assign waddr = AW'(tfn_pkg::slot_mod(req_ch.vertex_slot, VERTEX_SLOTS));
   assign raddr = AW'(tfn_pkg::slot_mod(corner_ff[cmd.step[1:0] == 2'd3 ? 2'd0 :
                                                  cmd.step[1:0]], VERTEX_SLOTS));

   tfn_ram #(.WIDTH(VW), .DEPTH(VERTEX_SLOTS)) u_table (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (waddr),
      .wdata ({req_ch.coord_x, req_ch.coord_y, req_ch.coord_z}),
      .raddr (raddr),
      .rdata (rdata)
   );

   // latch the triangle request and capture corner positions
   always_ff @(posedge clock) begin
      if (cmd.tri_start) begin
         corner_ff[0] <= req_ch.corner_a;
         corner_ff[1] <= req_ch.corner_b;
         corner_ff[2] <= req_ch.corner_c;
         final_ff     <= req_ch.final_triangle;
      end
      if (cmd.read_en && cmd.step != '0) begin
         pos_ff[cmd.step[1:0] - 2'd1] <= rdata;
      end
   end

   // edges from the first corner
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e1[j] = 18'(signed'(pos_ff[1][VW-1-16*j -: 16])) -
                 18'(signed'(pos_ff[0][VW-1-16*j -: 16]));
         e2[j] = 18'(signed'(pos_ff[2][VW-1-16*j -: 16])) -
                 18'(signed'(pos_ff[0][VW-1-16*j -: 16]));
         cr_mag[j] = cr_ff[j][34] ? 34'(-cr_ff[j]) : 34'(cr_ff[j]);
      end
   end

   // select square operands: component and partial product
   always_comb begin
      case (cmd.step)
         6'd0: begin sq_comp = 2'd0; part_in = PART_HH; end
         6'd1: begin sq_comp = 2'd0; part_in = PART_HL; end
         6'd2: begin sq_comp = 2'd0; part_in = PART_LL; end
         6'd3: begin sq_comp = 2'd1; part_in = PART_HH; end
         6'd4: begin sq_comp = 2'd1; part_in = PART_HL; end
         6'd5: begin sq_comp = 2'd1; part_in = PART_LL; end
         6'd6: begin sq_comp = 2'd2; part_in = PART_HH; end
         6'd7: begin sq_comp = 2'd2; part_in = PART_HL; end
         default: begin sq_comp = 2'd2; part_in = PART_LL; end
      endcase
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.cross_en) begin
         case (cmd.step)
            6'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
            6'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
            6'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
            6'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
            6'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
            6'd5: begin mul_a = e1[1]; mul_b = e2[0]; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (part_in)
            PART_HH: begin
               mul_a = signed'({1'b0, cr_mag[sq_comp][33:17]});
               mul_b = signed'({1'b0, cr_mag[sq_comp][33:17]});
            end
            PART_HL: begin
               mul_a = signed'({1'b0, cr_mag[sq_comp][33:17]});
               mul_b = signed'({1'b0, cr_mag[sq_comp][16:0]});
            end
            default: begin
               mul_a = signed'({1'b0, cr_mag[sq_comp][16:0]});
               mul_b = signed'({1'b0, cr_mag[sq_comp][16:0]});
            end
         endcase
      end
   end

   assign cross_idx = 3'(cmd.step - 1'b1);

   // weight the partial product of the square by its position
   always_comb begin
      case (part_ff)
         PART_HH: sq_term = SUM_W'(unsigned'(prod_ff)) << 34;
         PART_HL: sq_term = SUM_W'(unsigned'(prod_ff)) << 18;
         default: sq_term = SUM_W'(unsigned'(prod_ff));
      endcase
   end

   // multiply, then accumulate cross product and sum of squares
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      part_ff <= part_in;
      if (cmd.cross_en && cmd.step != '0) begin
         if (!cross_idx[0]) begin
            cr_ff[cross_idx[2:1]] <= 35'(prod_ff);
         end else begin
            cr_ff[cross_idx[2:1]] <= cr_ff[cross_idx[2:1]] - 35'(prod_ff);
         end
      end
      if (cmd.square_en) begin
         if (cmd.step == '0) begin
            sum_ff <= '0;
         end else begin
            sum_ff <= sum_ff + sq_term;
         end
      end
   end

   // square root: two operand bits a step
   assign rem_sh = {rem_ff[REM_W-3:0], sop_ff[SUM_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.sqrt_en) begin
         if (cmd.step == '0) begin
            rem_ff  <= '0;
            root_ff <= '0;
            sop_ff  <= sum_ff;
         end else if (cmd.step != tfn_pkg::SQRT_LAST) begin
            sop_ff <= sop_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign status.degenerate = (root_ff == '0);

   // rounded quotient, clamped and signed
   assign q_clamp  = (q_ff > ONE) ? ONE : q_ff;
   assign q_signed = sign_ff ? -signed'(64'(q_clamp)) : signed'(64'(q_clamp));

   // restoring division, one quotient bit a step
   always_ff @(posedge clock) begin
      if (cmd.tri_start) begin
         for (int j = 0; j < 3; j++) begin
            norm_ff[j] <= '0;
         end
      end
      if (cmd.div_en) begin
         if (cmd.step == '0) begin
            drem_ff <= (DW'(cr_mag[cmd.sel]) << COORD_FRAC_BITS) + DW'(root_ff >> 1);
            dsh_ff  <= DW'(root_ff) << COORD_FRAC_BITS;
            q_ff    <= '0;
            sign_ff <= cr_ff[cmd.sel][34];
         end else if (cmd.step <= DIV_ITER_LAST) begin
            dsh_ff <= dsh_ff >> 1;
            if (drem_ff >= dsh_ff) begin
               drem_ff <= drem_ff - dsh_ff;
               q_ff    <= {q_ff[QW-2:0], 1'b1};
            end else begin
               q_ff <= {q_ff[QW-2:0], 1'b0};
            end
         end else if (cmd.step == DIV_LAST) begin
            norm_ff[cmd.sel] <= q_signed[15:0];
         end
      end
   end

   // running vertex index
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else if (cmd.emit_fire) begin
         if (cmd.sel == tfn_pkg::SEL_LAST && final_ff) begin
            index_ff <= '0;
         end else begin
            index_ff <= index_ff + 1'b1;
         end
      end
   end

   // drive the result payload
   assign pos_sel                 = pos_ff[cmd.sel == 2'd3 ? 2'd0 : cmd.sel];
   assign rsp_ch.vertex_index     = index_ff;
   assign rsp_ch.pos_x            = pos_sel[47:32];
   assign rsp_ch.pos_y            = pos_sel[31:16];
   assign rsp_ch.pos_z            = pos_sel[15:0];
   assign rsp_ch.norm_x           = norm_ff[0];
   assign rsp_ch.norm_y           = norm_ff[1];
   assign rsp_ch.norm_z           = norm_ff[2];
   assign rsp_ch.degenerate       = status.degenerate;
   assign rsp_ch.last_of_triangle = (cmd.sel == tfn_pkg::SEL_LAST);
endmodule

// File: rtl/triangle_face_normal_unit_top.sv
// A load request is written into the vertex table on acceptance; a triangle request offers
// its first result after its read, cross product, square, square root and divide phases,
// paced by the iterative square root and the one-bit-a-step divider; degenerate triangles skip the divider.
// Throughput: one triangle at a time; the next request is taken after the third result.
// Reset: synchronous, clears the controller and the vertex index; the vertex table is
// not cleared and holds undefined data until written.
module triangle_face_normal_unit_top #(
   parameter int VERTEX_SLOTS    = tfn_pkg::VERTEX_SLOTS_DEF,
   parameter int COORD_FRAC_BITS = tfn_pkg::COORD_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   tfn_req_if.sink   req_ch,
   tfn_rsp_if.source rsp_ch
);
   tfn_pkg::dp_cmd_type    cmd;
   tfn_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   // sequence the request through the datapath
   tfn_ctrl #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // compute the normal and present results
   tfn_datapath #(
      .VERTEX_SLOTS    (VERTEX_SLOTS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );
endmodule
